@@ hw/rtl/rdpr_pkg.sv @@
// Shared types, constants and codes for the remote debug packet receiver.
package rdpr_pkg;

    localparam int BUF_DEPTH_DEFAULT = 2048;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_SEQ   = 8'h3A;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DESC = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] START_SEQ   = 2'd3;
    localparam logic [1:0] START_PLAIN = 2'd0;

    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic [10:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [1:0]  payload_start;
        logic [11:0] payload_length;
        logic [7:0]  read_data;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_READ = 2'd0,
        CMD_NAK  = 2'd1,
        CMD_ACK  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        seq;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [11:0] length;
        logic [7:0]  rdata;
    } cmd_t;

endpackage

@@ hw/rtl/rdpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/rdpr_front.sv @@
// Front end: packet deframing, payload store writes, read lookups, command issue.
module rdpr_front #(
    parameter int BUF_DEPTH = rdpr_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdpr_pkg::in_item_t in_item,
    output logic              push,
    output rdpr_pkg::cmd_t    push_cmd,
    input  logic              q_full
);
    import rdpr_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_DATA = 4'b0010,
        PH_DIG1 = 4'b0100,
        PH_DIG2 = 4'b1000
    } phase_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            v = 5'd16;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = 5'(c - 8'h30);
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = 5'(c - 8'h57);
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = 5'(c - 8'h37);
            end
            return v;
        end
    endfunction

    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     sum_reg, sum_next;
    logic [3:0]     high_reg, high_next;
    logic           bad_reg, bad_next;
    logic [7:0]     b0_reg, b0_next;
    logic [7:0]     b1_reg, b1_next;
    logic           colon_reg, colon_next;
    logic           s1_valid_reg, s1_valid_next;
    cmd_t           s1_cmd_reg, s1_cmd_next;
    logic           s1_oor_reg, s1_oor_next;

    logic           accept;
    logic [7:0]     c;
    logic [4:0]     hv;
    logic           wr_en;
    logic           rd_en;
    logic [7:0]     rd_data;
    logic [CW-1:0]  count_inc;

    assign in_ready  = !s1_valid_reg || !q_full;
    assign accept    = in_valid && in_ready;
    assign c         = in_item.rx_byte;
    assign hv        = hex_value(c);
    assign count_inc = count_reg + CW'(1);
    assign rd_en     = accept && in_item.operation;

    assign wr_en = accept && !in_item.operation && (phase_reg == PH_DATA)
                   && (c != CH_START) && (c != CH_END);

    rdpr_ram #(
        .WIDTH(8),
        .DEPTH(BUF_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(AW'(count_reg)),
        .wr_data(c),
        .rd_en  (rd_en),
        .rd_addr(AW'(in_item.read_index)),
        .rd_data(rd_data)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        high_next     = high_reg;
        bad_next      = bad_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        colon_next    = colon_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_oor_next   = s1_oor_reg;
        s1_valid_next = s1_valid_reg && q_full;

        if (accept)
        begin
            s1_valid_next = 1'b0;
            if (in_item.operation)
            begin
                s1_valid_next     = 1'b1;
                s1_cmd_next       = '0;
                s1_cmd_next.kind  = CMD_READ;
                s1_oor_next = {21'd0, in_item.read_index} >= 32'(BUF_DEPTH);
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (c == CH_START)
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (c == CH_START)
                        begin
                            count_next = '0;
                            sum_next   = '0;
                        end
                        else if (c == CH_END)
                        begin
                            phase_next = PH_DIG1;
                        end
                        else
                        begin
                            if (count_reg == CW'(0))
                            begin
                                b0_next = c;
                            end
                            if (count_reg == CW'(1))
                            begin
                                b1_next = c;
                            end
                            if (count_reg == CW'(2))
                            begin
                                colon_next = (c == CH_SEQ);
                            end
                            sum_next   = sum_reg + c;
                            count_next = count_inc;
                            if (count_inc == CW'(BUF_DEPTH))
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                    end
                    PH_DIG1:
                    begin
                        bad_next   = hv[4];
                        high_next  = hv[3:0];
                        phase_next = PH_DIG2;
                    end
                    PH_DIG2:
                    begin
                        phase_next         = PH_HUNT;
                        s1_valid_next      = 1'b1;
                        s1_oor_next        = 1'b0;
                        s1_cmd_next        = '0;
                        s1_cmd_next.b0     = b0_reg;
                        s1_cmd_next.b1     = b1_reg;
                        s1_cmd_next.length = 12'(count_reg);
                        s1_cmd_next.seq    = colon_reg && (count_reg >= CW'(3));
                        if (bad_reg || hv[4] || ({high_reg, hv[3:0]} != sum_reg))
                        begin
                            s1_cmd_next.kind = CMD_NAK;
                        end
                        else
                        begin
                            s1_cmd_next.kind = CMD_ACK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        push_cmd       = s1_cmd_reg;
        push_cmd.rdata = (s1_cmd_reg.kind == CMD_READ && !s1_oor_reg) ? rd_data : 8'd0;
    end

    assign push = s1_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            count_reg    <= '0;
            sum_reg      <= '0;
            high_reg     <= '0;
            bad_reg      <= 1'b0;
            colon_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            high_reg     <= high_next;
            bad_reg      <= bad_next;
            colon_reg    <= colon_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg     <= b0_next;
        b1_reg     <= b1_next;
        s1_cmd_reg <= s1_cmd_next;
        s1_oor_reg <= s1_oor_next;
    end

endmodule

@@ hw/rtl/rdpr_queue.sv @@
// Short command queue between the front end and the back end.
module rdpr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rdpr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rdpr_pkg::cmd_t head_cmd
);
    import rdpr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;

    assign full       = (fill_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/rdpr_back.sv @@
// Back end: expand queued commands into result transfers through an output register.
module rdpr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  rdpr_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output rdpr_pkg::out_item_t out_item
);
    import rdpr_pkg::*;

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;
    out_item_t  res;
    logic       load;

    always_comb
    begin
        res = '0;
        case (head_cmd.kind)
            CMD_READ:
            begin
                res.kind      = KIND_READ;
                res.read_data = head_cmd.rdata;
                res.last      = 1'b1;
            end
            CMD_NAK:
            begin
                res.kind    = KIND_TX;
                res.tx_byte = CH_NAK;
                res.last    = 1'b1;
            end
            CMD_ACK:
            begin
                if (step_reg == 2'd0)
                begin
                    res.kind    = KIND_TX;
                    res.tx_byte = CH_ACK;
                end
                else if (head_cmd.seq && step_reg == 2'd1)
                begin
                    res.kind    = KIND_TX;
                    res.tx_byte = head_cmd.b0;
                end
                else if (head_cmd.seq && step_reg == 2'd2)
                begin
                    res.kind    = KIND_TX;
                    res.tx_byte = head_cmd.b1;
                end
                else
                begin
                    res.kind           = KIND_DESC;
                    res.payload_start  = head_cmd.seq ? START_SEQ : START_PLAIN;
                    res.payload_length = head_cmd.length;
                    res.last           = 1'b1;
                end
            end
            default:
            begin
                res.last = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && res.last;

    always_comb
    begin
        step_next      = step_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
            step_next      = res.last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ hw/rtl/remote_debug_packet_receiver.sv @@
// Top level of the remote debug packet receiver.
//
// Input channel (in_valid/in_ready/in_item): one link byte or one payload read
// per transfer. Link bytes deframe "$payload#hh" packets; payload bytes go to
// a BUF_DEPTH-byte store, one write per cycle while in_ready is high.
// Output channel (out_valid/out_ready/out_item): result transfers. A good
// checksum gives '+', two sequence-id bytes if present, then a descriptor;
// a bad one gives '-'; a read gives one read-data result. last marks the
// final result of an input transfer.
// Throughput: one input transfer per cycle while the command queue has room.
// The output side moves one result per cycle while out_ready is high, so a
// packet end with a sequence id occupies the back end for four results.
// Path: a result passes through the front stage (with store read), the queue
// and the output register in turn before it appears on out_valid.
// Reset: hunting for '$', queue and output register empty; store contents
// are undefined until written.
// Stall: when out_ready is low the output register holds, the queue fills,
// and in_ready drops once the queue is full and the front stage holds a command.
module remote_debug_packet_receiver #(
    parameter int BUF_DEPTH = rdpr_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rdpr_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rdpr_pkg::out_item_t out_item
);
    import rdpr_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    rdpr_front #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item (in_item),
        .push    (push),
        .push_cmd(push_cmd),
        .q_full  (q_full)
    );

    rdpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    rdpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
